// ===== rtl/core/kmeq_pkg.sv =====
// ----------------------------------------------------------------------------
// kmeq_pkg
// Shared types, constants and the key map for the key matrix edge queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  // wide enough for the depth itself and for the 4-bit reported count
  localparam int CNT_W       = (PTR_W + 1 > 4) ? PTR_W + 1 : 4;

  localparam int ROW_W   = 3;
  localparam int BITS_W  = 5;
  localparam int COL_W   = 3;
  localparam int CODE_W  = 7;
  localparam int COUNT_W = 4;
  localparam int DROP_W  = 3;

  localparam logic [BITS_W-1:0] ROW_RELEASED = 5'h1F;
  localparam logic [CODE_W-1:0] KEY_NONE     = 7'h00;
  localparam logic [CODE_W-1:0] KEY_BS       = 7'h08;
  localparam logic [CODE_W-1:0] KEY_CR       = 7'h0D;
  localparam logic [ROW_W-1:0]  CAPS_ROW     = 3'd4;
  localparam logic [COL_W-1:0]  CAPS_COL     = 3'd0;
  localparam logic [COL_W-1:0]  LAST_COL     = 3'd4;

  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] wdata;
  } ring_cmd_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [COUNT_W-1:0] count;
    logic [CODE_W-1:0]  rdata;
  } ring_stat_t;

  function automatic logic [CODE_W-1:0] key_map(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    logic [CODE_W-1:0] code;
    code = KEY_NONE;
    case ({row, col})
      6'o01:   code = 7'h5A; // Z
      6'o02:   code = 7'h58; // X
      6'o03:   code = 7'h43; // C
      6'o04:   code = 7'h56; // V
      6'o10:   code = 7'h41; // A
      6'o11:   code = 7'h53; // S
      6'o12:   code = 7'h44; // D
      6'o13:   code = 7'h46; // F
      6'o14:   code = 7'h47; // G
      6'o20:   code = 7'h51; // Q
      6'o21:   code = 7'h57; // W
      6'o22:   code = 7'h45; // E
      6'o23:   code = 7'h52; // R
      6'o24:   code = 7'h54; // T
      6'o50:   code = 7'h50; // P
      6'o51:   code = 7'h4F; // O
      6'o52:   code = 7'h49; // I
      6'o53:   code = 7'h55; // U
      6'o54:   code = 7'h59; // Y
      6'o60:   code = KEY_CR;
      6'o61:   code = 7'h4C; // L
      6'o62:   code = 7'h4B; // K
      6'o63:   code = 7'h4A; // J
      6'o64:   code = 7'h48; // H
      6'o70:   code = 7'h20; // space
      6'o72:   code = 7'h4D; // M
      6'o73:   code = 7'h4E; // N
      6'o74:   code = 7'h42; // B
      default: code = KEY_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kmeq_ram.sv =====
// ----------------------------------------------------------------------------
// kmeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/kmeq_ring.sv =====
// ----------------------------------------------------------------------------
// kmeq_ring
// Key ring: read and write pointers, full and empty compare, fill count,
// and the key store RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmeq_ring (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kmeq_pkg::ring_cmd_t  cmd,
  output kmeq_pkg::ring_stat_t      stat
);

  logic [kmeq_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [kmeq_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [kmeq_pkg::PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [kmeq_pkg::PTR_W:0]   wr_sum, rd_sum;
  logic [kmeq_pkg::CNT_W-1:0] fill;
  logic [kmeq_pkg::CODE_W-1:0] rdata;

  // pointer increment with wrap at the ring depth
  assign wr_sum = (kmeq_pkg::PTR_W+1)'(wr_ptr_r) + (kmeq_pkg::PTR_W+1)'(1);
  assign rd_sum = (kmeq_pkg::PTR_W+1)'(rd_ptr_r) + (kmeq_pkg::PTR_W+1)'(1);
  assign wr_ptr_inc = (wr_sum == (kmeq_pkg::PTR_W+1)'(kmeq_pkg::QUEUE_DEPTH)) ?
                      '0 : wr_sum[kmeq_pkg::PTR_W-1:0];
  assign rd_ptr_inc = (rd_sum == (kmeq_pkg::PTR_W+1)'(kmeq_pkg::QUEUE_DEPTH)) ?
                      '0 : rd_sum[kmeq_pkg::PTR_W-1:0];

  assign wr_ptr_nxt = cmd.push ? wr_ptr_inc : wr_ptr_r;
  assign rd_ptr_nxt = cmd.pop  ? rd_ptr_inc : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  assign fill = kmeq_pkg::CNT_W'(wr_ptr_r) - kmeq_pkg::CNT_W'(rd_ptr_r) +
                ((wr_ptr_r < rd_ptr_r) ? kmeq_pkg::CNT_W'(kmeq_pkg::QUEUE_DEPTH) :
                                         kmeq_pkg::CNT_W'(0));

  // read port follows the read pointer; the read data is registered
  kmeq_ram #(
    .WIDTH (kmeq_pkg::CODE_W),
    .DEPTH (kmeq_pkg::QUEUE_DEPTH),
    .ADDR_W(kmeq_pkg::PTR_W)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(wr_ptr_r),
    .wdata(cmd.wdata),
    .raddr(rd_ptr_r),
    .rdata(rdata)
  );

  always_comb begin
    stat.empty = (rd_ptr_r == wr_ptr_r);
    stat.full  = (wr_ptr_inc == rd_ptr_r);
    stat.count = fill[kmeq_pkg::COUNT_W-1:0];
    stat.rdata = rdata;
  end

endmodule

`default_nettype wire

// ===== rtl/core/key_matrix_edge_queue_core.sv =====
// ----------------------------------------------------------------------------
// key_matrix_edge_queue_core
// Keyboard half-row scanner with press-edge detection and a key ring.
// ----------------------------------------------------------------------------
// scan: ST_SCAN steps columns 0 to 4, then ST_DONE strobes the result;
//   the key map and ring compare handle one key bit per cycle over 5 bits
// pop: ST_POP, then ST_DONE strobes (ST_DONE directly when the ring is empty);
//   ST_POP covers the registered read of the key store
// reset (rst_n low, synchronous): idle, all rows released, ring empty;
//   the key store itself is not cleared; results are never held off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_edge_queue_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [kmeq_pkg::ROW_W-1:0]    in_row_index,
  input  wire logic [kmeq_pkg::BITS_W-1:0]   in_row_bits,
  input  wire logic                          in_caps_bit,
  output logic                               out_valid,
  output logic                               out_key_valid,
  output logic      [kmeq_pkg::CODE_W-1:0]   out_key_code,
  output logic      [kmeq_pkg::COUNT_W-1:0]  out_queue_count,
  output logic      [kmeq_pkg::DROP_W-1:0]   out_keys_dropped
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_t;

  state_t                         state_r;
  logic [kmeq_pkg::BITS_W-1:0]    last_rows_r [8];
  logic [kmeq_pkg::BITS_W-1:0]    edges_r;
  logic [kmeq_pkg::ROW_W-1:0]     row_r;
  logic [kmeq_pkg::COL_W-1:0]     col_r;
  logic                           caps_r;
  logic                           key_valid_r;
  logic [kmeq_pkg::CODE_W-1:0]    key_code_r;
  logic [kmeq_pkg::DROP_W-1:0]    dropped_r;

  logic [kmeq_pkg::CODE_W-1:0]    key;
  logic                           key_new;
  kmeq_pkg::ring_cmd_t            ring_cmd;
  kmeq_pkg::ring_stat_t           ring_stat;
  logic                           accept;

  assign accept = start && (state_r == ST_IDLE);

  // one key bit per cycle through the map
  always_comb begin
    key = kmeq_pkg::key_map(row_r, col_r);
    if (row_r == kmeq_pkg::CAPS_ROW && col_r == kmeq_pkg::CAPS_COL && !caps_r) begin
      key = kmeq_pkg::KEY_BS;
    end
    key_new = (state_r == ST_SCAN) && edges_r[col_r] && (key != kmeq_pkg::KEY_NONE);
  end

  always_comb begin
    ring_cmd.push  = key_new && !ring_stat.full;
    ring_cmd.pop   = (state_r == ST_POP);
    ring_cmd.wdata = key;
  end

  kmeq_ring u_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ring_cmd),
    .stat (ring_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        last_rows_r[i] <= kmeq_pkg::ROW_RELEASED;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            row_r       <= in_row_index;
            caps_r      <= in_caps_bit;
            col_r       <= '0;
            key_valid_r <= 1'b0;
            key_code_r  <= kmeq_pkg::KEY_NONE;
            dropped_r   <= '0;
            if (in_func == kmeq_pkg::FUNC_SCAN) begin
              edges_r                   <= last_rows_r[in_row_index] & ~in_row_bits;
              last_rows_r[in_row_index] <= in_row_bits;
              state_r                   <= ST_SCAN;
            end else if (ring_stat.empty) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_POP;
            end
          end
        end
        ST_SCAN: begin
          if (key_new && ring_stat.full) begin
            dropped_r <= dropped_r + kmeq_pkg::DROP_W'(1);
          end
          col_r <= col_r + kmeq_pkg::COL_W'(1);
          if (col_r == kmeq_pkg::LAST_COL) begin
            state_r <= ST_DONE;
          end
        end
        ST_POP: begin
          key_valid_r <= 1'b1;
          key_code_r  <= ring_stat.rdata;
          state_r     <= ST_DONE;
        end
        ST_DONE: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_key_valid    = key_valid_r;
  assign out_key_code     = key_code_r;
  assign out_queue_count  = ring_stat.count;
  assign out_keys_dropped = dropped_r;

endmodule

`default_nettype wire

// ===== rtl/core/kmeq_checker.sv =====
// ----------------------------------------------------------------------------
// kmeq_checker
// Port-level checks of the command handshake and result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmeq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic                          out_key_valid,
  input wire logic [kmeq_pkg::CODE_W-1:0]   out_key_code,
  input wire logic [kmeq_pkg::DROP_W-1:0]   out_keys_dropped
);

  // a transfer always makes the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  // result strobe only while a command is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a popped key never reports drops
  a_pop_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_valid) |-> (out_keys_dropped == '0))
    else $error("drops reported on a pop");

  a_no_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_key_valid) |-> (out_key_code == kmeq_pkg::KEY_NONE))
    else $error("key code without a key");

endmodule

bind key_matrix_edge_queue_core kmeq_checker u_kmeq_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key matrix edge queue: a directed table of
// scans and pops, then phased random traffic that fills and drains the ring,
// each result checked against a pinned want or model of rows, key map, ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import kmeq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
    logic [COUNT_W-1:0] queue_count;
    logic [DROP_W-1:0]  keys_dropped;
  } key_result_t;

  typedef struct packed {
    logic              func;
    logic [ROW_W-1:0]  row_index;
    logic [BITS_W-1:0] row_bits;
    logic              caps_bit;
    logic              pinned;
    key_result_t       want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_func;
  logic [ROW_W-1:0] in_row_index;
  logic [BITS_W-1:0] in_row_bits;
  logic in_caps_bit;
  logic out_valid;
  logic out_key_valid;
  logic [CODE_W-1:0] out_key_code;
  logic [COUNT_W-1:0] out_queue_count;
  logic [DROP_W-1:0] out_keys_dropped;

  // hand-typed result that travels with the item being driven
  logic chk_pin;
  key_result_t chk_want;

  // local copy of the block state
  logic [BITS_W-1:0] held_rows [8];
  logic [CODE_W-1:0] key_ring [QUEUE_DEPTH];
  int ring_rd;
  int ring_wr;

  key_result_t pending_results [$];
  stim_row_t directed_rows [$];

  int cycle_count;
  int fail_count;
  int mismatch_count;
  int n_scans;
  int n_pops;
  int n_keys_popped;
  int n_empty_pops;
  int n_keys_dropped;
  int n_full_scans;

  key_matrix_edge_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .in_caps_bit      (in_caps_bit),
    .out_valid        (out_valid),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_queue_count  (out_queue_count),
    .out_keys_dropped (out_keys_dropped)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ascii code of one key, column 0 in the low bits of each half-row line
  function automatic logic [CODE_W-1:0] ascii_for_key(input logic [ROW_W-1:0] row,
                                                      input int col);
    logic [5*CODE_W-1:0] line;
    case (row)
      3'd0: line = {7'h56, 7'h43, 7'h58, 7'h5A, KEY_NONE};
      3'd1: line = {7'h47, 7'h46, 7'h44, 7'h53, 7'h41};
      3'd2: line = {7'h54, 7'h52, 7'h45, 7'h57, 7'h51};
      3'd5: line = {7'h59, 7'h55, 7'h49, 7'h4F, 7'h50};
      3'd6: line = {7'h48, 7'h4A, 7'h4B, 7'h4C, KEY_CR};
      3'd7: line = {7'h42, 7'h4E, 7'h4D, KEY_NONE, 7'h20};
      default: line = {5{KEY_NONE}};
    endcase
    return line[col*CODE_W +: CODE_W];
  endfunction

  function automatic int ring_next(input int p);
    return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  task automatic predict_key_result(input logic f, input logic [ROW_W-1:0] r,
                                    input logic [BITS_W-1:0] b, input logic c,
                                    output key_result_t res);
    logic [BITS_W-1:0] pressed;
    logic [CODE_W-1:0] code;
    int nxt;
    res = '0;
    if (f == FUNC_SCAN) begin
      n_scans++;
      pressed = held_rows[r] & ~b;
      held_rows[r] = b;
      for (int k = 0; k < BITS_W; k++) begin
        if (pressed[k]) begin
          code = ascii_for_key(r, k);
          if (r == CAPS_ROW && k == CAPS_COL && c == 1'b0) begin
            code = KEY_BS;
          end
          if (code != KEY_NONE) begin
            nxt = ring_next(ring_wr);
            if (nxt != ring_rd) begin
              key_ring[ring_wr] = code;
              ring_wr = nxt;
            end else begin
              res.keys_dropped = res.keys_dropped + 1'b1;
            end
          end
        end
      end
      if (res.keys_dropped != 0) begin
        n_full_scans++;
        n_keys_dropped += res.keys_dropped;
      end
    end else begin
      n_pops++;
      if (ring_rd != ring_wr) begin
        res.key_valid = 1'b1;
        res.key_code = key_ring[ring_rd];
        ring_rd = ring_next(ring_rd);
        n_keys_popped++;
      end else begin
        n_empty_pops++;
      end
    end
    res.queue_count = COUNT_W'((ring_wr + QUEUE_DEPTH - ring_rd) % QUEUE_DEPTH);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic f, input logic [ROW_W-1:0] r,
                           input logic [BITS_W-1:0] b, input logic c,
                           input logic pin, input key_result_t want,
                           input bit may_idle);
    while (may_idle && $urandom_range(99) < 11) begin
      start <= 1'b0;
      in_func <= 1'($urandom);
      in_row_index <= ROW_W'($urandom);
      in_row_bits <= BITS_W'($urandom);
      in_caps_bit <= 1'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_row_index <= r;
    in_row_bits <= b;
    in_caps_bit <= c;
    chk_pin <= pin;
    chk_want <= want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // transfer in, result out
  always @(posedge clk) begin
    key_result_t pred;
    key_result_t got;
    key_result_t want;
    if (rst_n && start && !busy) begin
      predict_key_result(in_func, in_row_index, in_row_bits, in_caps_bit, pred);
      pending_results.push_back(chk_pin ? chk_want : pred);
    end
    if (rst_n && out_valid) begin
      got = {out_key_valid, out_key_code, out_queue_count, out_keys_dropped};
      if (pending_results.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] result with nothing pending: valid %0d code %h count %0d drop %0d",
                   $realtime, got.key_valid, got.key_code, got.queue_count,
                   got.keys_dropped);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
            got.queue_count !== want.queue_count ||
            got.keys_dropped !== want.keys_dropped) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: valid %0d/%0d code %h/%h count %0d/%0d drop %0d/%0d",
                     $realtime, got.key_valid, want.key_valid, got.key_code,
                     want.key_code, got.queue_count, want.queue_count,
                     got.keys_dropped, want.keys_dropped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic f;
    logic c;
    logic [ROW_W-1:0] r;
    logic [BITS_W-1:0] b;
    int pop_pct;
    int sel;
    bit may_idle;

    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_SCAN;
    in_row_index = '0;
    in_row_bits = ROW_RELEASED;
    in_caps_bit = 1'b1;
    chk_pin = 1'b0;
    chk_want = '0;
    cycle_count = 0;
    fail_count = 0;
    mismatch_count = 0;
    n_scans = 0;
    n_pops = 0;
    n_keys_popped = 0;
    n_empty_pops = 0;
    n_keys_dropped = 0;
    n_full_scans = 0;
    ring_rd = 0;
    ring_wr = 0;
    for (int i = 0; i < 8; i++) begin
      held_rows[i] = ROW_RELEASED;
    end

    // func, row, bits, caps, pinned, {valid, code, count, dropped}
    directed_rows.push_back({FUNC_POP,  3'd0, 5'h1F, 1'b1, 1'b1, 1'b0, KEY_NONE, 4'd0, 3'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd0, 5'h00, 1'b1, 1'b1, 1'b0, KEY_NONE, 4'd4, 3'd0});
    directed_rows.push_back({FUNC_POP,  3'd7, 5'h00, 1'b0, 1'b1, 1'b1, 7'h5A, 4'd3, 3'd0});
    // caps-shift with key 0 is backspace, without caps the key is unused
    directed_rows.push_back({FUNC_SCAN, 3'd4, 5'h1E, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd4, 5'h1F, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd4, 5'h1E, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd3, 5'h00, 1'b1, 1'b1, 1'b0, KEY_NONE, 4'd4, 3'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd6, 5'h00, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd7, 5'h00, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd7, 5'h00, 1'b0, 1'b0, 15'd0});
    // ring fills at fifteen keys, the rest is dropped
    directed_rows.push_back({FUNC_SCAN, 3'd1, 5'h00, 1'b1, 1'b1, 1'b0, KEY_NONE, 4'd15, 3'd3});
    directed_rows.push_back({FUNC_SCAN, 3'd2, 5'h00, 1'b0, 1'b1, 1'b0, KEY_NONE, 4'd15, 3'd5});
    directed_rows.push_back({FUNC_POP,  3'd2, 5'h15, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd0, 5'h1F, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd0, 5'h0A, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd5, 5'h00, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_POP,  3'd5, 5'h00, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_POP,  3'd1, 5'h1F, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_POP,  3'd6, 5'h0F, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_POP,  3'd3, 5'h10, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_POP,  3'd4, 5'h01, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_POP,  3'd0, 5'h1F, 1'b0, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd4, 5'h1F, 1'b1, 1'b0, 15'd0});
    directed_rows.push_back({FUNC_SCAN, 3'd4, 5'h00, 1'b0, 1'b0, 15'd0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.func, row.row_index, row.row_bits, row.caps_bit, row.pinned,
                row.want, 1'b1);
    end

    // phases cycle through filling, balanced and draining traffic on the ring
    for (int blk = 0; blk < 14; blk++) begin
      case (blk % 3)
        0: pop_pct = 15;
        1: pop_pct = 50;
        default: pop_pct = 85;
      endcase
      may_idle = !(blk == 6 || blk == 7);
      for (int n = 0; n < 100; n++) begin
        r = ROW_W'($urandom_range(7));
        c = 1'($urandom);
        f = ($urandom_range(99) < pop_pct) ? FUNC_POP : FUNC_SCAN;
        sel = $urandom_range(99);
        if (sel < 50) begin
          b = held_rows[r] ^ (BITS_W'(1) << $urandom_range(BITS_W - 1));
        end else if (sel < 65) begin
          b = (held_rows[r] == ROW_RELEASED) ? '0 : ROW_RELEASED;
        end else begin
          b = BITS_W'($urandom);
        end
        send_item(f, r, b, c, 1'b0, '0, may_idle);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
    end

    $display("covered %0d scans (%0d hit a full ring, %0d keys dropped) and %0d pops",
             n_scans, n_full_scans, n_keys_dropped, n_pops);
    $display("%0d keys popped, %0d pops on an empty ring, %0d mismatches",
             n_keys_popped, n_empty_pops, mismatch_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
